// ===== design/threshold_promoted_recency_cache_unit_macros.svh =====
// Assertion macros used by the checker file of the recency cache.
`ifndef THRESHOLD_PROMOTED_RECENCY_CACHE_UNIT_MACROS_SVH
`define THRESHOLD_PROMOTED_RECENCY_CACHE_UNIT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define TRPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define TRPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/trpc_pkg.sv =====
package trpc_pkg;

  // Number of entries in the recency list.
  localparam int ENTRIES = 16;

  // Widths derived from the entry count.
  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W = $clog2(ENTRIES + 1);

  // Fixed field widths, and the compare width that covers fill level and capacity.
  localparam int KEY_W = 64;
  localparam int CNT_W = 16;
  localparam int CAP_W = 5;
  localparam int THR_W = 16;
  localparam int OCC_W = 5;
  localparam int CMP_W = (FILL_W > CAP_W) ? FILL_W : CAP_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Reset values of the configuration registers.
  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);
  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(1);

  // Request modes.
  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Register indexes on the configuration port.
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] page_key;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] request_count;
    logic             promoted;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [OCC_W-1:0] occupancy;
  } res_t;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic [THR_W-1:0] threshold;
  } cfg_t;

endpackage

// ===== design/trpc_cfg.sv =====
module trpc_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output trpc_pkg::cfg_t      cfg_o
);
  import trpc_pkg::*;

  logic [CAP_W-1:0] capacity_q;
  logic [THR_W-1:0] threshold_q;
  logic             reg_index;
  logic             wr_en;

  assign reg_index = paddr[2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes complete in the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
      threshold_q <= THRESHOLD_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_CAPACITY:  capacity_q <= pwdata[CAP_W-1:0];
        REG_THRESHOLD: threshold_q <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data follows the addressed register.
  always_comb begin
    unique case (reg_index)
      REG_CAPACITY:  prdata = 32'(capacity_q);
      REG_THRESHOLD: prdata = 32'(threshold_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.capacity = capacity_q;
  assign cfg_o.threshold = threshold_q;

endmodule

// ===== design/trpc_store.sv =====
module trpc_store (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  trpc_pkg::req_t req_i,
  input  trpc_pkg::cfg_t cfg_i,
  output trpc_pkg::res_t res_o
);
  import trpc_pkg::*;

  logic [KEY_W-1:0]  key_q   [ENTRIES];
  logic [CNT_W-1:0]  count_q [ENTRIES];
  logic [RANK_W-1:0] rank_q  [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [FILL_W-1:0]  fill_q;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] tail_sel;
  logic [ENTRIES-1:0] valid_kept;
  logic [ENTRIES-1:0] slot;
  logic               slot_taken;
  logic [CNT_W-1:0]   hit_cnt;
  logic [RANK_W-1:0]  hit_rank;
  logic [KEY_W-1:0]   tail_key;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CMP_W-1:0]   cap_ext;
  logic [CMP_W-1:0]   eff_cap;
  logic [RANK_W-1:0]  tail_rank;
  logic [FILL_W-1:0]  fill_miss;
  logic [FILL_W-1:0]  fill_next;
  logic               is_clear;
  logic               is_hit;
  logic               is_miss;
  logic               promote;
  logic               evict_due;
  logic               evict;

  assign is_clear = (req_i.mode == MODE_CLEAR);
  assign tail_rank = RANK_W'(fill_q - FILL_W'(1));

  // Per-entry key compare and tail lookup; the matching entry's fields are ORed out.
  always_comb begin
    hit_cnt = '0;
    hit_rank = '0;
    tail_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (key_q[i] == req_i.page_key);
      tail_sel[i] = valid_q[i] && (rank_q[i] == tail_rank);
      if (match[i]) begin
        hit_cnt = hit_cnt | count_q[i];
        hit_rank = hit_rank | rank_q[i];
      end
      if (tail_sel[i]) begin
        tail_key = tail_key | key_q[i];
      end
    end
  end

  assign is_hit = !is_clear && (|match);
  assign is_miss = !is_clear && !(|match);

  // Saturating count and the promotion decision.
  assign cnt_inc = (hit_cnt == COUNT_MAX) ? hit_cnt : hit_cnt + CNT_W'(1);
  assign promote = is_hit && (cnt_inc > cfg_i.threshold) && (hit_rank != '0);

  // Capacity is clamped to the range one to the entry count.
  always_comb begin
    cap_ext = CMP_W'(cfg_i.capacity);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign evict_due = is_miss && (CMP_W'(fill_q) >= eff_cap) && (fill_q != '0);
  assign evict = evict_due && (|tail_sel);

  // Pick the lowest free entry after the tail has been dropped.
  always_comb begin
    slot_taken = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      valid_kept[i] = valid_q[i] && !(evict && tail_sel[i]);
      slot[i] = !valid_kept[i] && !slot_taken;
      slot_taken = slot_taken || !valid_kept[i];
    end
  end

  assign fill_miss = fill_q - FILL_W'(evict) + FILL_W'(slot_taken);

  always_comb begin
    if (is_clear) begin
      fill_next = '0;
    end else if (is_miss) begin
      fill_next = fill_miss;
    end else begin
      fill_next = fill_q;
    end
  end

  // Valid bits and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fill_q <= '0;
    end else if (fire_i) begin
      if (is_clear) begin
        valid_q <= '0;
      end else if (is_miss) begin
        valid_q <= valid_kept | slot;
      end
      fill_q <= fill_next;
    end
  end

  // Entry payload: count update, rank shifts and insertion at the head.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (fire_i && is_hit) begin
        if (match[i]) begin
          count_q[i] <= cnt_inc;
          if (promote) begin
            rank_q[i] <= '0;
          end
        end else if (promote && valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_q[i] <= rank_q[i] + RANK_W'(1);
        end
      end else if (fire_i && is_miss) begin
        if (slot[i]) begin
          key_q[i] <= req_i.page_key;
          count_q[i] <= CNT_W'(1);
          rank_q[i] <= '0;
        end else if (valid_kept[i]) begin
          rank_q[i] <= rank_q[i] + RANK_W'(1);
        end
      end
    end
  end

  // Result of this request.
  always_comb begin
    res_o.hit = is_hit;
    if (is_hit) begin
      res_o.request_count = cnt_inc;
    end else if (is_miss) begin
      res_o.request_count = CNT_W'(1);
    end else begin
      res_o.request_count = '0;
    end
    res_o.promoted = promote;
    res_o.evicted = evict;
    res_o.evicted_key = evict ? tail_key : '0;
    res_o.occupancy = OCC_W'(fill_next);
  end

endmodule

// ===== design/threshold_promoted_recency_cache_unit.sv =====
// Threshold-promoted recency cache.
// Requests enter on the in channel (in_valid_i, in_stall_o) with mode_i and
// page_key_i; mode 0 looks up a page, mode 1 clears the whole store. Each
// request gives exactly one result on the out channel (out_valid_o,
// out_stall_i): hit flag, saturated request count, promotion and eviction
// flags, the evicted key and the occupancy after the request.
// A request is captured in an input register, runs through the parallel key
// compare and list update, and lands in a result register, from which the
// result is offered. One request is taken every clock as long as the
// receiver keeps taking results.
// When the receiver stalls, the result register holds its value, the request
// in the input register waits, and in_stall_o rises once both are occupied.
// The user writes capacity and threshold over the APB port only while the
// block is idle; the block does not enforce this. Reset empties the store,
// drops any request in flight and sets capacity to 16 and threshold to 1.
module threshold_promoted_recency_cache_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [63:0] page_key_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [15:0] request_count_o,
  output logic        promoted_o,
  output logic        evicted_o,
  output logic [63:0] evicted_key_o,
  output logic [4:0]  occupancy_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import trpc_pkg::*;

  logic in_full_q;
  req_t in_req_q;
  logic out_valid_q;
  res_t res_q;
  res_t res;
  cfg_t cfg;
  logic advance;
  logic accept;

  trpc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The held request moves on whenever the result register is free or drains.
  assign advance = in_full_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_full_q && !advance;
  assign accept = in_valid_i && !in_stall_o;

  trpc_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .req_i  (in_req_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Control of the input and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_full_q <= 1'b1;
      end else if (advance) begin
        in_full_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_req_q.mode <= mode_i;
      in_req_q.page_key <= page_key_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o = res_q.hit;
  assign request_count_o = res_q.request_count;
  assign promoted_o = res_q.promoted;
  assign evicted_o = res_q.evicted;
  assign evicted_key_o = res_q.evicted_key;
  assign occupancy_o = res_q.occupancy;

endmodule

// ===== design/trpc_checker.sv =====
`include "threshold_promoted_recency_cache_unit_macros.svh"

module trpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        hit_o,
  input logic [15:0] request_count_o,
  input logic        promoted_o,
  input logic        evicted_o,
  input logic [63:0] evicted_key_o,
  input logic [4:0]  occupancy_o
);
  import trpc_pkg::*;

  // A stalled result stays offered, with its hit flag, count, evicted key and occupancy unchanged.
  `TRPC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o) && $stable(request_count_o) && $stable(evicted_key_o) && $stable(occupancy_o), "stalled result changed")

  // Only a hit can promote, and a hit never evicts.
  `TRPC_ASSERT(a_promote_hit, out_valid_o && (promoted_o || evicted_o) |-> (promoted_o == hit_o) && !(hit_o && evicted_o), "promotion or eviction flags inconsistent with hit")

  // An eviction happens on a miss that inserts a fresh entry, so the store stays non-empty.
  `TRPC_ASSERT(a_evict_miss, out_valid_o && evicted_o |-> request_count_o == 16'd1 && occupancy_o != 5'd0, "eviction result fields wrong")

  // Occupancy never exceeds the number of entries.
  `TRPC_ASSERT(a_occ_bound, out_valid_o |-> occupancy_o <= 5'(ENTRIES), "occupancy above entry count")

endmodule

bind threshold_promoted_recency_cache_unit trpc_checker u_trpc_checker (.*);

// ===== dv/trpc_recency_checker.sv =====
module trpc_recency_checker
  import trpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             mode_i,
  input  logic [KEY_W-1:0] page_key_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic             hit_i,
  input  logic [CNT_W-1:0] request_count_i,
  input  logic             promoted_i,
  input  logic             evicted_i,
  input  logic [KEY_W-1:0] evicted_key_i,
  input  logic [OCC_W-1:0] occupancy_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [2:0]       paddr_i,
  input  logic [31:0]      pwdata_i,
  input  logic             pready_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CAPACITY_ADDR  = {REG_CAPACITY, 2'b00};
  localparam logic [2:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};

  // Shadow copy of the configuration registers.
  logic [CAP_W-1:0] capacity_q;
  logic [THR_W-1:0] threshold_q;

  // Shadow copy of the recency list.
  logic [KEY_W-1:0] slot_key   [ENTRIES];
  logic [CNT_W-1:0] slot_count [ENTRIES];
  int               slot_rank  [ENTRIES];
  bit               slot_valid [ENTRIES];
  int               fill_level;

  // Results predicted for accepted requests, oldest first.
  res_t predicted_results[$];
  res_t observed, oldest, fresh;
  req_t accepted;

  initial fail_count_o = 0;
  initial pending_o = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    fail_count_o++;
  endtask

  function automatic int usable_capacity();
    if (capacity_q == '0) return 1;
    if (capacity_q > ENTRIES) return ENTRIES;
    return int'(capacity_q);
  endfunction

  task automatic empty_list();
    for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
    fill_level = 0;
  endtask

  // Applies one request to the shadow list and works out its result.
  task automatic serve_page_request(input req_t rq, output res_t rs);
    int found, free_slot, tail_rank, old_rank;
    logic [CNT_W-1:0] cnt;
    rs = '0;
    if (rq.mode == MODE_CLEAR) begin
      empty_list();
    end else begin
      found = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (found < 0 && slot_valid[i] && slot_key[i] == rq.page_key) found = i;
      end
      if (found >= 0) begin
        // Hit: bump the count and move to the head once above the threshold.
        cnt = slot_count[found];
        if (cnt != COUNT_MAX) cnt = cnt + CNT_W'(1);
        slot_count[found] = cnt;
        rs.hit = 1'b1;
        rs.request_count = cnt;
        old_rank = slot_rank[found];
        if (cnt > threshold_q && old_rank != 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && slot_rank[i] < old_rank) slot_rank[i]++;
          end
          slot_rank[found] = 0;
          rs.promoted = 1'b1;
        end
      end else begin
        // Miss: drop the tail when full, then insert at the head.
        if (fill_level >= usable_capacity() && fill_level > 0) begin
          tail_rank = fill_level - 1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!rs.evicted && slot_valid[i] && slot_rank[i] == tail_rank) begin
              rs.evicted = 1'b1;
              rs.evicted_key = slot_key[i];
              slot_valid[i] = 1'b0;
              fill_level--;
            end
          end
        end
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i]) slot_rank[i]++;
          else if (free_slot < 0) free_slot = i;
        end
        if (free_slot >= 0) begin
          slot_key[free_slot] = rq.page_key;
          slot_count[free_slot] = CNT_W'(1);
          slot_rank[free_slot] = 0;
          slot_valid[free_slot] = 1'b1;
          fill_level++;
        end
        rs.request_count = CNT_W'(1);
      end
    end
    rs.occupancy = OCC_W'(fill_level);
  endtask

  task automatic compare_result(input res_t got, input res_t want);
    if (got.hit != want.hit)
      report_mismatch($sformatf("hit got %0d, expected %0d", got.hit, want.hit));
    if (got.request_count != want.request_count)
      report_mismatch($sformatf("request_count got %0d, expected %0d",
                                got.request_count, want.request_count));
    if (got.promoted != want.promoted)
      report_mismatch($sformatf("promoted got %0d, expected %0d",
                                got.promoted, want.promoted));
    if (got.evicted != want.evicted)
      report_mismatch($sformatf("evicted got %0d, expected %0d",
                                got.evicted, want.evicted));
    if (got.evicted_key != want.evicted_key)
      report_mismatch($sformatf("evicted_key got %016h, expected %016h",
                                got.evicted_key, want.evicted_key));
    if (got.occupancy != want.occupancy)
      report_mismatch($sformatf("occupancy got %0d, expected %0d",
                                got.occupancy, want.occupancy));
  endtask

  // Watch the register port and both channels at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q = CAPACITY_RESET;
      threshold_q = THRESHOLD_RESET;
      empty_list();
      predicted_results.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i)
          CAPACITY_ADDR: begin
            capacity_q = pwdata_i[CAP_W-1:0];
          end
          THRESHOLD_ADDR: begin
            threshold_q = pwdata_i[THR_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        accepted.mode = mode_i;
        accepted.page_key = page_key_i;
        serve_page_request(accepted, fresh);
        predicted_results.push_back(fresh);
      end
      if (out_valid_i && !out_stall_i) begin
        observed = '{hit_i, request_count_i, promoted_i, evicted_i, evicted_key_i,
                     occupancy_i};
        if (predicted_results.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          oldest = predicted_results.pop_front();
          compare_result(observed, oldest);
        end
      end
    end
    pending_o = predicted_results.size();
  end

endmodule

// ===== dv/tb_threshold_promoted_recency_cache_unit.sv =====
module tb_threshold_promoted_recency_cache_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import trpc_pkg::*;

  localparam logic [2:0] CAPACITY_ADDR  = {REG_CAPACITY, 2'b00};
  localparam logic [2:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};
  localparam int DRAIN_LIMIT = 5000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             mode_i = MODE_REQUEST;
  logic [KEY_W-1:0] page_key_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             hit_o;
  logic [CNT_W-1:0] request_count_o;
  logic             promoted_o;
  logic             evicted_o;
  logic [KEY_W-1:0] evicted_key_o;
  logic [OCC_W-1:0] occupancy_o;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  int fail_count;
  int pending_count;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;

  threshold_promoted_recency_cache_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .page_key_i      (page_key_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .request_count_o (request_count_o),
    .promoted_o      (promoted_o),
    .evicted_o       (evicted_o),
    .evicted_key_o   (evicted_key_o),
    .occupancy_o     (occupancy_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  trpc_recency_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .mode_i          (mode_i),
    .page_key_i      (page_key_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_i           (hit_o),
    .request_count_i (request_count_o),
    .promoted_i      (promoted_o),
    .evicted_i       (evicted_o),
    .evicted_key_i   (evicted_key_o),
    .occupancy_i     (occupancy_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .pready_i        (pready),
    .fail_count_o    (fail_count),
    .pending_o       (pending_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // One APB write: setup cycle, then access cycle until pready.
  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offers one request after a random gap and holds it until it is taken.
  task automatic send_request(input logic mode, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    page_key_i <= key;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Stops sending and waits until every outstanding result has come back or the wait limit is reached.
  task automatic drain();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic configure(input int capacity, input int threshold);
    drain();
    write_register(CAPACITY_ADDR, 32'(capacity));
    write_register(THRESHOLD_ADDR, 32'(threshold));
  endtask

  task automatic directed_requests();
    logic [KEY_W-1:0] old_key;
    // Empty store, head hit, promotion, and tail eviction at a small capacity.
    configure(3, 1);
    send_request(MODE_REQUEST, '0);
    send_request(MODE_REQUEST, '0);
    send_request(MODE_REQUEST, '1);
    send_request(MODE_REQUEST, '0);
    send_request(MODE_REQUEST, random_key());
    send_request(MODE_REQUEST, random_key());
    send_request(MODE_CLEAR, random_key());
    send_request(MODE_REQUEST, '0);
    // Capacity of zero behaves as one; a hit on the head is never promoted.
    configure(0, 0);
    old_key = random_key();
    send_request(MODE_REQUEST, old_key);
    send_request(MODE_REQUEST, random_key());
    send_request(MODE_REQUEST, page_key_i);
    // Oversized capacity fills every entry; the top threshold blocks promotion.
    configure(31, 65535);
    old_key = random_key();
    send_request(MODE_REQUEST, old_key);
    repeat (14) send_request(MODE_REQUEST, random_key());
    send_request(MODE_REQUEST, old_key);
    // Capacity lowered below occupancy: one out, one in.
    configure(2, 1);
    send_request(MODE_REQUEST, random_key());
    send_request(MODE_REQUEST, old_key);
  endtask

  // Random requests over a small key pool with a hot subset, plus clears
  // and fresh keys.
  task automatic random_segment(input int count);
    logic [KEY_W-1:0] pool [24];
    int pool_len, hot_len, pick;
    pool_len = $urandom_range(24, 2);
    hot_len = $urandom_range(3, 1);
    for (int i = 0; i < 24; i++) pool[i] = random_key();
    for (int j = 0; j < count; j++) begin
      pick = $urandom_range(99);
      if (pick < 3) send_request(MODE_CLEAR, random_key());
      else if (pick < 10) send_request(MODE_REQUEST, random_key());
      else if (pick < 50) send_request(MODE_REQUEST, pool[$urandom_range(hot_len - 1)]);
      else send_request(MODE_REQUEST, pool[$urandom_range(pool_len - 1)]);
    end
  endtask

  task automatic random_configure();
    int capacity, threshold;
    case ($urandom_range(5))
      0: capacity = 0;
      1: capacity = 1;
      2: capacity = 16;
      3: capacity = 31;
      default: capacity = $urandom_range(15, 2);
    endcase
    case ($urandom_range(5))
      0: threshold = 0;
      1: threshold = 1;
      2: threshold = 65535;
      default: threshold = $urandom_range(6, 2);
    endcase
    configure(capacity, threshold);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_gap_pct = 33;
          rx_stall_pct = 55;
        end
        1: begin
          tx_gap_pct = 55;
          rx_stall_pct = 33;
        end
        default: begin
          tx_gap_pct = 0;
          rx_stall_pct = 0;
        end
      endcase
      if (phase == 0) directed_requests();
      for (int seg = 0; seg < 4; seg++) begin
        random_configure();
        random_segment(96);
      end
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/trpc_pkg.sv
design/trpc_cfg.sv
design/trpc_store.sv
design/threshold_promoted_recency_cache_unit.sv
design/trpc_checker.sv
dv/trpc_recency_checker.sv
dv/tb_threshold_promoted_recency_cache_unit.sv
